### design/dtfp_pkg.sv
// Package for the date text field parser: payload structs, config codes,
// constants and the small arithmetic helpers. No dependencies.
package dtfp_pkg;

  localparam int unsigned MAX_CHARS = 255;

  localparam int unsigned CharW   = 8;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned AccW    = 16;
  localparam int unsigned OrdW    = 2;
  localparam int unsigned EpochW  = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QuoW    = 8;   // epoch_year / 100 fits 8 bits
  localparam int unsigned LoW     = 7;   // epoch_year % 100

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;

  localparam logic [AccW-1:0] ACC_MAX  = '1;
  localparam logic [AccW-1:0] CENTURY  = 16'd100;

  // floor(v / 100) == (v * 5243) >> 19 for every 14-bit v
  localparam int unsigned RecipMul   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned ProdW      = EpochW + RecipW;

  localparam logic [OrdW-1:0]   DAY_ORDER_RST   = 2'd2;
  localparam logic [OrdW-1:0]   MONTH_ORDER_RST = 2'd1;
  localparam logic [OrdW-1:0]   YEAR_ORDER_RST  = 2'd3;
  localparam logic [EpochW-1:0] EPOCH_RST       = 14'd1900;
  localparam logic [QuoW-1:0]   EPOCH_QUO_RST   = 8'd19;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAY_ORDER   = 2'd0,
    CFG_MONTH_ORDER = 2'd1,
    CFG_YEAR_ORDER  = 2'd2,
    CFG_EPOCH_YEAR  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [AccW-1:0] day;
    logic [AccW-1:0] month;
    logic [AccW-1:0] year;
    logic [IdxW-1:0] stop_index;
  } out_item_t;

  // Settings seen by the character step
  typedef struct packed {
    logic [OrdW-1:0]   day_order;
    logic [OrdW-1:0]   month_order;
    logic [OrdW-1:0]   year_order;
    logic [EpochW-1:0] epoch_base;   // (epoch_year / 100) * 100
    logic [LoW-1:0]    epoch_lo;     // epoch_year % 100
  } cfg_t;

  function automatic logic [AccW-1:0] add_digit(input logic [AccW-1:0] acc,
                                                input logic [3:0] dig);
    logic [AccW+3:0] v;
    v = ((AccW+4)'(acc) << 3) + ((AccW+4)'(acc) << 1) + (AccW+4)'(dig);
    return (v > (AccW+4)'(ACC_MAX)) ? ACC_MAX : v[AccW-1:0];
  endfunction

  function automatic logic [OrdW-1:0] slot_down(input logic [OrdW-1:0] s);
    return (s != '0) ? s - OrdW'(1) : '0;
  endfunction

  function automatic logic [AccW-1:0] widen_year(input logic [AccW-1:0]   y,
                                                 input logic [EpochW-1:0] base,
                                                 input logic [LoW-1:0]    lo);
    logic [AccW-1:0] w;
    w = y + AccW'(base);
    if (y >= CENTURY) begin
      return y;
    end else if (y >= AccW'(lo)) begin
      return w;
    end
    return w + CENTURY;
  endfunction

endpackage

### design/date_text_field_parser.sv
// Top level of the date text field parser: input register, character step,
// result register and config port. Depends on dtfp_pkg, dtfp_cfg, dtfp_step.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | in_data_i  (char_code, last_char)
//  out     | source    | out_valid_o / out_ready_i | out_data_o (day, month, year,
//          |           |                           |             stop_index)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One character per cycle. A character is held in the input register, is
// folded into the parse state as it leaves, and on a final character the
// result lands in the output register, which holds it until it is taken.
// Reset empties both registers and marks the next character as a string start.
// A stalled result only blocks a final character; other characters keep going.
// Config writes are always taken; the epoch split is valid from the next edge.
module date_text_field_parser #(
  parameter int unsigned MaxChars = dtfp_pkg::MAX_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dtfp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dtfp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtfp_pkg::EpochW-1:0]   cfg_data_i
);
  import dtfp_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      out_valid_q;
  logic      proc;
  cfg_t      cfg;

  // Process the held character unless it is final and the result slot is full
  assign proc = in_valid_q &&
                (!in_q.last_char || !out_valid_q || out_ready_i);

  assign in_ready_o  = !in_valid_q || proc;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc && in_q.last_char) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc && in_q.last_char) begin
      out_q <= res;
    end
  end

  dtfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtfp_step #(
    .MaxChars (MaxChars)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proc),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/dtfp_cfg.sv
// Configuration registers of the date text field parser, with the split of
// the epoch year into century base and remainder. Depends on dtfp_pkg.
module dtfp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [dtfp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dtfp_pkg::EpochW-1:0]     cfg_data_i,
  output dtfp_pkg::cfg_t                  cfg_o
);
  import dtfp_pkg::*;

  logic [OrdW-1:0]   day_ord_q, month_ord_q, year_ord_q;
  logic [EpochW-1:0] epoch_q;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [ProdW-1:0]  prod;
  logic [EpochW-1:0] base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_ord_q   <= DAY_ORDER_RST;
      month_ord_q <= MONTH_ORDER_RST;
      year_ord_q  <= YEAR_ORDER_RST;
      epoch_q     <= EPOCH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DAY_ORDER:   day_ord_q   <= cfg_data_i[OrdW-1:0];
        CFG_MONTH_ORDER: month_ord_q <= cfg_data_i[OrdW-1:0];
        CFG_YEAR_ORDER:  year_ord_q  <= cfg_data_i[OrdW-1:0];
        CFG_EPOCH_YEAR:  epoch_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Divide by 100 via reciprocal, captured together with the epoch register
  assign prod  = ProdW'(cfg_data_i) * ProdW'(RecipMul);
  assign quo_d = prod[RecipShift +: QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= EPOCH_QUO_RST;
    end else if (cfg_valid_i && (cfg_reg_e'(cfg_index_i) == CFG_EPOCH_YEAR)) begin
      quo_q <= quo_d;
    end
  end

  assign base = EpochW'(quo_q) * EpochW'(100);

  assign cfg_o.day_order   = day_ord_q;
  assign cfg_o.month_order = month_ord_q;
  assign cfg_o.year_order  = year_ord_q;
  assign cfg_o.epoch_base  = base;
  assign cfg_o.epoch_lo    = LoW'(epoch_q - base);

endmodule

### design/dtfp_step.sv
// Parse state and per-character update of the date text field parser.
// Produces the result of a final character combinationally. Depends on dtfp_pkg.
module dtfp_step #(
  parameter int unsigned MaxChars = dtfp_pkg::MAX_CHARS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dtfp_pkg::in_item_t   item_i,
  input  dtfp_pkg::cfg_t       cfg_i,
  output dtfp_pkg::out_item_t  res_o
);
  import dtfp_pkg::*;

  logic [AccW-1:0] day_q, month_q, year_q;
  logic [AccW-1:0] day_c, month_c, year_c, day_d, month_d, year_d;
  logic [OrdW-1:0] dslot_q, mslot_q, yslot_q;
  logic [OrdW-1:0] dslot_c, mslot_c, yslot_c, dslot_d, mslot_d, yslot_d;
  logic            sep_q, sep_c, sep_d;
  logic            fin_q, fin_c, fin_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] stop_q, stop_c, stop_d;
  logic            first;
  logic            is_digit;
  logic            all_set;
  logic [3:0]      dig;
  logic [CharW-1:0] c;

  assign c        = item_i.char_code;
  assign first    = (idx_q == '0);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign dig      = 4'(c - CHAR_ZERO);

  // Start-of-string view of the state
  always_comb begin
    day_c   = first ? '0 : day_q;
    month_c = first ? '0 : month_q;
    year_c  = first ? '0 : year_q;
    dslot_c = first ? cfg_i.day_order   : dslot_q;
    mslot_c = first ? cfg_i.month_order : mslot_q;
    yslot_c = first ? cfg_i.year_order  : yslot_q;
    sep_c   = first ? 1'b1 : sep_q;
    fin_c   = first ? 1'b0 : fin_q;
    stop_c  = first ? '0 : stop_q;
  end

  assign all_set = (day_c != '0) && (month_c != '0) && (year_c != '0);

  always_comb begin
    day_d   = day_c;
    month_d = month_c;
    year_d  = year_c;
    dslot_d = dslot_c;
    mslot_d = mslot_c;
    yslot_d = yslot_c;
    sep_d   = sep_c;
    fin_d   = fin_c;
    stop_d  = stop_c;
    idx_d   = idx_q;
    if (idx_q < IdxW'(MaxChars)) begin
      if (!fin_c) begin
        if (is_digit) begin
          if (dslot_c == OrdW'(1)) begin
            day_d = add_digit(day_c, dig);
          end else if (mslot_c == OrdW'(1)) begin
            month_d = add_digit(month_c, dig);
          end else if (yslot_c == OrdW'(1)) begin
            year_d = add_digit(year_c, dig);
          end
          sep_d = 1'b0;
        end else if (all_set) begin
          fin_d  = 1'b1;
          stop_d = idx_q;
        end else if (c != CHAR_SPACE) begin
          if (!sep_c) begin
            dslot_d = slot_down(dslot_c);
            mslot_d = slot_down(mslot_c);
            yslot_d = slot_down(yslot_c);
          end
          sep_d = 1'b1;
        end
      end
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    res_o.day        = day_d;
    res_o.month      = month_d;
    res_o.year       = widen_year(year_d, cfg_i.epoch_base, cfg_i.epoch_lo);
    res_o.stop_index = fin_d ? stop_d : idx_d;
  end

  // Index zero marks a fresh string; everything else is reloaded from it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (step_i) begin
      idx_q <= item_i.last_char ? '0 : idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      dslot_q <= dslot_d;
      mslot_q <= mslot_d;
      yslot_q <= yslot_d;
      sep_q   <= sep_d;
      fin_q   <= fin_d;
      stop_q  <= stop_d;
    end
  end

endmodule

### design/dtfp_checker.sv
// Port-level checks for the date text field parser, bound to the top level.
// Depends on dtfp_pkg and date_text_field_parser.
module dtfp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  dtfp_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  dtfp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [dtfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtfp_pkg::EpochW-1:0]   cfg_data_i
);
  import dtfp_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // With no result waiting, the input side never stalls
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result slot");

  // Every string holds at least one character, and no parse stops on the first
  a_stop_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.stop_index != '0)
    else $error("stop index of zero");

  // Config writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind date_text_field_parser dtfp_checker u_dtfp_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for date_text_field_parser: streams date text one
// character per transaction, predicts every parse result and checks it.
// Depends on dtfp_pkg and the date_text_field_parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfp_pkg::*;

  typedef logic [CharW-1:0] text_q_t[$];

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [EpochW-1:0]  cfg_data_i  = '0;

  always #6 clk_i = ~clk_i;

  date_text_field_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Idle rates in percent: sender gaps and receiver stalls
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;

  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned results_checked;
  int unsigned mismatches;

  // ---------------------------------------------------------------------------
  // Date parse predictor: a private copy of the format registers and of the
  // per-string parse state, updated on every accepted character transaction.
  // ---------------------------------------------------------------------------
  logic [OrdW-1:0]   fmt_day_pos   = DAY_ORDER_RST;
  logic [OrdW-1:0]   fmt_month_pos = MONTH_ORDER_RST;
  logic [OrdW-1:0]   fmt_year_pos  = YEAR_ORDER_RST;
  logic [EpochW-1:0] fmt_epoch     = EPOCH_RST;

  logic [AccW-1:0] day_sum, month_sum, year_sum;
  logic [OrdW-1:0] day_slot, month_slot, year_slot;
  bit              sep_seen;     // a separator already counted (or string start)
  bit              parse_done;   // all three fields set and a terminator seen
  int unsigned     char_pos;
  int unsigned     stop_pos;

  // Parsed dates still owed by the DUT, oldest first
  out_item_t expected_dates[$];
  out_item_t want;

  function automatic logic [AccW-1:0] shift_in_digit(input logic [AccW-1:0] acc,
                                                     input int unsigned dig);
    int unsigned v;
    v = acc * 10 + dig;
    return (v > 65535) ? 16'hFFFF : AccW'(v);
  endfunction

  function automatic logic [OrdW-1:0] step_down(input logic [OrdW-1:0] s);
    return (s == '0) ? s : s - 1'b1;
  endfunction

  // Slots reload from the format registers at each string start
  function automatic void restart_parse();
    day_sum    = '0;
    month_sum  = '0;
    year_sum   = '0;
    day_slot   = fmt_day_pos;
    month_slot = fmt_month_pos;
    year_slot  = fmt_year_pos;
    sep_seen   = 1'b1;
    parse_done = 1'b0;
    char_pos   = 0;
    stop_pos   = 0;
  endfunction

  function automatic void fold_char(input logic [CharW-1:0] c);
    bit all_set;
    all_set = (day_sum != 0) && (month_sum != 0) && (year_sum != 0);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      // first field with slot 1 wins; with no slot at 1 the digit is dropped
      if (day_slot == 1) begin
        day_sum = shift_in_digit(day_sum, c - CHAR_ZERO);
      end else if (month_slot == 1) begin
        month_sum = shift_in_digit(month_sum, c - CHAR_ZERO);
      end else if (year_slot == 1) begin
        year_sum = shift_in_digit(year_sum, c - CHAR_ZERO);
      end
      sep_seen = 1'b0;
    end else if (all_set) begin
      parse_done = 1'b1;
      stop_pos   = char_pos;
    end else if (c != CHAR_SPACE) begin
      // a run of separators moves the slots only once
      if (!sep_seen) begin
        day_slot   = step_down(day_slot);
        month_slot = step_down(month_slot);
        year_slot  = step_down(year_slot);
      end
      sep_seen = 1'b1;
    end
  endfunction

  // Two-digit years pivot about the epoch: below its low part -> next century
  function automatic logic [AccW-1:0] expand_year(input logic [AccW-1:0] y);
    int unsigned lo, hi;
    lo = fmt_epoch % 100;
    hi = fmt_epoch / 100;
    if (y >= 100) return y;
    if (y >= lo) return AccW'(y + hi * 100);
    return AccW'(y + hi * 100 + 100);
  endfunction

  function automatic void predict_char(input in_item_t it);
    out_item_t res;
    if (char_pos == 0) restart_parse();
    // bytes past MAX_CHARS are counted no further and never parsed
    if (char_pos < MAX_CHARS) begin
      if (!parse_done) fold_char(it.char_code);
      char_pos++;
    end
    if (it.last_char) begin
      res.day        = day_sum;
      res.month      = month_sum;
      res.year       = expand_year(year_sum);
      res.stop_index = IdxW'(parse_done ? stop_pos : char_pos);
      expected_dates.push_back(res);
      restart_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and every result transaction is compared
  // against the oldest predicted date.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void check_field(input string field, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_dates.size() == 0) begin
        $display("%0t ns: result with none expected: day %0d month %0d year %0d stop %0d",
                 $time, out_data_o.day, out_data_o.month, out_data_o.year,
                 out_data_o.stop_index);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        check_field("day", want.day, out_data_o.day);
        check_field("month", want.month, out_data_o.month);
        check_field("year", want.year, out_data_o.year);
        check_field("stop_index", want.stop_index, out_data_o.stop_index);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks start and end right after a rising edge and drive with
  // nonblocking assignments, so the DUT sees stable values at the next edge.
  // ---------------------------------------------------------------------------

  // One character transaction, with random sender gaps in front of it.
  // Valid is left high after acceptance; the next call or the drain lowers it.
  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    in_item_t it;
    it.char_code = c;
    it.last_char = last;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_char(it);
    chars_sent++;
  endtask

  task automatic send_text(input text_q_t s);
    for (int i = 0; i < s.size(); i++) begin
      send_char(s[i], i == s.size() - 1);
    end
    strings_sent++;
  endtask

  function automatic text_q_t text_of(input string str);
    text_q_t s;
    for (int i = 0; i < str.len(); i++) s.push_back(str[i]);
    return s;
  endfunction

  // Wait until every owed date has come back, plus the parse pipeline depth
  task automatic wait_parser_idle();
    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [EpochW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DAY_ORDER:   fmt_day_pos   = val[OrdW-1:0];
      CFG_MONTH_ORDER: fmt_month_pos = val[OrdW-1:0];
      CFG_YEAR_ORDER:  fmt_year_pos  = val[OrdW-1:0];
      default:         fmt_epoch     = val;
    endcase
  endtask

  // Rewrites the whole format while the parser is idle. Order writes carry
  // random upper bits, which the DUT must drop.
  task automatic load_format(input logic [OrdW-1:0] d, input logic [OrdW-1:0] m,
                             input logic [OrdW-1:0] y, input logic [EpochW-1:0] e);
    logic [EpochW-1:0] junk;
    wait_parser_idle();
    junk = EpochW'($urandom);
    write_reg(CFG_DAY_ORDER, {junk[EpochW-1:OrdW], d});
    junk = EpochW'($urandom);
    write_reg(CFG_MONTH_ORDER, {junk[EpochW-1:OrdW], m});
    junk = EpochW'($urandom);
    write_reg(CFG_YEAR_ORDER, {junk[EpochW-1:OrdW], y});
    write_reg(CFG_EPOCH_YEAR, e);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_random_format();
    logic [OrdW-1:0]   d, m, y;
    logic [EpochW-1:0] e;
    if ($urandom_range(99) < 70) begin
      // a proper field order, as a real date format gives
      d = OrdW'($urandom_range(1, 3));
      m = OrdW'($urandom_range(1, 3));
      while (m == d) m = OrdW'($urandom_range(1, 3));
      y = OrdW'(6 - int'(d) - int'(m));
    end else begin
      // absent, repeated or passed fields
      d = OrdW'($urandom_range(3));
      m = OrdW'($urandom_range(3));
      y = OrdW'($urandom_range(3));
    end
    case ($urandom_range(4))
      0:       e = '0;
      1:       e = '1;
      2:       e = EpochW'(9999);
      3:       e = EpochW'($urandom_range(1900, 2100));
      default: e = EpochW'($urandom);
    endcase
    load_format(d, m, y, e);
  endtask

  function automatic logic [CharW-1:0] any_non_digit();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  function automatic logic [CharW-1:0] pick_separator();
    case ($urandom_range(6))
      0:       return "/";
      1:       return "-";
      2:       return ".";
      3:       return ",";
      4, 5:    return CHAR_SPACE;
      default: return any_non_digit();
    endcase
  endfunction

  // Mostly date-shaped text with random content; some strings have too few
  // or too many fields, some are plain byte noise.
  function automatic text_q_t random_date_text();
    text_q_t     s;
    int unsigned kind, groups, width;
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 12)) s.push_back(CharW'($urandom_range(255)));
      return s;
    end
    repeat ($urandom_range(0, 2)) s.push_back(pick_separator());
    groups = (kind < 30) ? $urandom_range(1, 2) : ((kind < 90) ? 3 : 4);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) begin
        repeat ($urandom_range(1, 2)) s.push_back(pick_separator());
      end
      // long digit runs push the accumulators into saturation
      width = ($urandom_range(19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      repeat (width) s.push_back(CHAR_ZERO + CharW'($urandom_range(9)));
    end
    repeat ($urandom_range(0, 3)) s.push_back(CharW'($urandom_range(255)));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset format (month, day, year, epoch 1900): a terminated parse with
  // trailing bytes ignored, and a one-character string.
  task automatic test_default_format();
    send_text(text_of("12/9/99 z"));
    send_text(text_of("5"));
  endtask

  // Equal orders with year first, epoch 0: year saturates, a digit that comes
  // while no slot is at 1 is dropped, day wins the tie.
  task automatic test_order_corners();
    load_format(2'd3, 2'd3, 2'd1, '0);
    send_text(text_of("123456/2-1"));
  endtask

  // Largest epoch (low part above the year) and all fields absent
  task automatic test_epoch_extremes();
    load_format(2'd1, 2'd2, 2'd3, '1);
    send_text(text_of("1/2/5"));
    load_format(2'd0, 2'd0, 2'd0, EpochW'(9999));
    send_text(text_of("7"));
  endtask

  // A string that runs past MAX_CHARS: the year digits fall beyond the limit
  // and the reported length saturates.
  task automatic test_long_string();
    text_q_t s;
    load_format(DAY_ORDER_RST, MONTH_ORDER_RST, YEAR_ORDER_RST, EPOCH_RST);
    repeat (250) s.push_back(CHAR_SPACE);
    s = {s, text_of("12/1/99")};
    send_text(s);
  endtask

  // Random text in three idle mixes, each across several random formats
  task automatic test_random_mix();
    int unsigned goal;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_gap_pct    = 14;
          out_stall_pct = 49;
        end
        1: begin
          in_gap_pct    = 49;
          out_stall_pct = 14;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      repeat (4) begin
        load_random_format();
        goal = chars_sent + 18;
        while (chars_sent < goal) send_text(random_date_text());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    restart_parse();
    in_gap_pct    = 14;
    out_stall_pct = 49;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_format();
    test_order_corners();
    test_epoch_extremes();
    test_long_string();
    test_random_mix();
    wait_parser_idle();

    $display("Parsed %0d strings (%0d characters), %0d dates checked, %0d mismatches.",
             strings_sent, chars_sent, results_checked, mismatches);
    $display("Covered reset and corner formats, epoch extremes, an over-length string, "
             , "and random text under three idle mixes.");
    if (mismatches == 0) begin
      $display("date_text_field_parser regression: pass");
    end else begin
      $display("date_text_field_parser regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d dates still owed.", expected_dates.size());
    $display("date_text_field_parser regression: fail");
    $finish;
  end

endmodule
